FILE: rtl/mmjc_pkg.sv
// Shared constants, state type and color helper for the jet colormap renderer.
`default_nettype none

package mmjc_pkg;

   localparam int STORE_DEPTH    = 4096;
   localparam int STORE_IDX_BITS = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS     = STORE_IDX_BITS + 1;
   localparam int INDEX_BITS     = 12;
   localparam int SAMPLE_BITS    = 32;
   localparam int FRAC_BITS      = 12;
   localparam int QUO_BITS       = FRAC_BITS + 1;
   localparam int QCNT_BITS      = $clog2(QUO_BITS);
   localparam int CH_BITS        = FRAC_BITS + 5;
   localparam int ONE            = 1 << FRAC_BITS;

   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // piece breaks on the intensity
   localparam logic [QUO_BITS-1:0] T_BREAK1 = QUO_BITS'(ONE / 8);
   localparam logic [QUO_BITS-1:0] T_BREAK2 = QUO_BITS'(3 * ONE / 8);
   localparam logic [QUO_BITS-1:0] T_BREAK3 = QUO_BITS'(5 * ONE / 8);
   localparam logic [QUO_BITS-1:0] T_BREAK4 = QUO_BITS'(7 * ONE / 8);

   // channel offsets in Q.FRAC_BITS
   localparam logic signed [CH_BITS-1:0] CH_ONE      = CH_BITS'(ONE);
   localparam logic signed [CH_BITS-1:0] CH_HALF     = CH_BITS'(ONE / 2);
   localparam logic signed [CH_BITS-1:0] CH_3HALF    = CH_BITS'(3 * ONE / 2);
   localparam logic signed [CH_BITS-1:0] CH_5HALF    = CH_BITS'(5 * ONE / 2);
   localparam logic signed [CH_BITS-1:0] CH_7HALF    = CH_BITS'(7 * ONE / 2);
   localparam logic signed [CH_BITS-1:0] CH_9HALF    = CH_BITS'(9 * ONE / 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_MAP
   } mmjc_state_type;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   // clamp a channel to [0, one] and scale by 255 with truncation
   function automatic logic [7:0] chan_to_byte(input logic signed [CH_BITS-1:0] c);
      logic [QUO_BITS-1:0]    cl;
      logic [FRAC_BITS+8:0]   prod;
      if (c < 0) begin
         cl = '0;
      end else if (c > CH_ONE) begin
         cl = QUO_BITS'(ONE);
      end else begin
         cl = c[QUO_BITS-1:0];
      end
      prod = {cl, 8'd0} - (FRAC_BITS+9)'(cl);
      return prod[FRAC_BITS+7:FRAC_BITS];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mmjc_divider.sv
// Restoring divider, one quotient bit a cycle, for the normalized intensity.
`default_nettype none

module mmjc_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                div_start,
   input  wire logic [mmjc_pkg::SAMPLE_BITS-1:0]    dividend,
   input  wire logic [mmjc_pkg::SAMPLE_BITS-1:0]    divisor,
   output logic                                     div_done,
   output logic [mmjc_pkg::QUO_BITS-1:0]            quotient
);
   import mmjc_pkg::*;

   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] den_ff;
   logic [QUO_BITS-1:0]    q_ff, q_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic [SAMPLE_BITS:0]   shifted;
   logic [SAMPLE_BITS+1:0] diff;
   logic                   ge;

   localparam logic [QCNT_BITS-1:0] LAST_STEP = QCNT_BITS'(QUO_BITS - 1);

   // first step takes the dividend as is (for a loaded index it never exceeds the divisor)
   always_comb begin
      shifted = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      ge      = !diff[SAMPLE_BITS+1];
      div_done = run_ff && (cnt_ff == LAST_STEP);
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      if (div_start) begin
         rem_in = dividend;
         q_in   = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
         q_in   = {q_ff[QUO_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (div_start) begin
         den_ff <= divisor;
      end
   end

   assign quotient = q_ff;

endmodule

`default_nettype wire

FILE: rtl/minmax_normalized_jet_colormap.sv
// Top level of the min/max normalized jet colormap heat-map renderer.
//
// Request channel: a request is taken at a rising edge where start is high
// and busy is low. A load request (req_op = 0) stores req_sample_value and
// widens the running minimum and maximum; req_first_of_frame restarts the
// frame. A load finishes at the edge that takes it and gives no response,
// so busy stays low and loads can follow every cycle.
// A render request (req_op = 1) reads the stored sample at req_pixel_index,
// normalizes it against the frame's min and max with a restoring divider
// (one quotient bit a cycle), maps it through the five-piece
// jet colormap and shows one response.
// Response channel: rsp_valid is high for exactly one cycle with rsp_red,
// rsp_green, rsp_blue and rsp_index_ok; the receiver cannot stall it.
// Render path: the memory read lands at the accepting edge, then the
// setup state, 13 divider steps and the color-map state lead to the
// registered response. Busy drops in the cycle that shows it, so the next
// request is taken at the edge that ends the response; a new request
// waits until the previous render is through, held by the serial divider.
// Reset clears min, max, the loaded count and the sequencer; the sample
// store is not cleared, since only entries below the count reach a color.
`default_nettype none

module minmax_normalized_jet_colormap (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_op,
   input  wire logic signed [mmjc_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  wire logic                               req_first_of_frame,
   input  wire logic [mmjc_pkg::INDEX_BITS-1:0]    req_pixel_index,
   output logic                                    rsp_valid,
   output logic [7:0]                              rsp_red,
   output logic [7:0]                              rsp_green,
   output logic [7:0]                              rsp_blue,
   output logic                                    rsp_index_ok
);
   import mmjc_pkg::*;

   mmjc_state_type state_ff, state_in;

   // frame statistics, kept in offset binary so unsigned order is signed order
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic [SAMPLE_BITS-1:0] sample_store [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic                   ok_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             red_ff, red_in;
   logic [7:0]             green_ff, green_in;
   logic [7:0]             blue_ff, blue_in;
   logic                   index_ok_ff, index_ok_in;

   logic                   accept;
   logic                   load_accept;
   logic                   render_accept;
   logic [SAMPLE_BITS-1:0] key;
   logic                   store_write;

   logic                   div_start;
   logic                   div_done;
   logic [QUO_BITS-1:0]    div_q;
   logic [SAMPLE_BITS-1:0] num;
   logic [SAMPLE_BITS-1:0] den;

   logic signed [CH_BITS-1:0] u;
   logic signed [CH_BITS-1:0] r_ch, g_ch, b_ch;

   assign busy          = (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign load_accept   = accept && (req_op == OP_LOAD);
   assign render_accept = accept && (req_op == OP_RENDER);
   assign key           = SAMPLE_BITS'(req_sample_value) ^ SIGN_FLIP;
   assign store_write   = load_accept &&
                          (req_first_of_frame || (count_ff < COUNT_BITS'(STORE_DEPTH)));

   // frame statistics: restart on the first flag, otherwise widen
   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      count_in = count_ff;
      if (load_accept) begin
         if (req_first_of_frame) begin
            min_in   = key;
            max_in   = key;
            count_in = COUNT_BITS'(1);
         end else begin
            if (key > max_ff) max_in = key;
            if (key < min_ff) min_in = key;
            if (count_ff < COUNT_BITS'(STORE_DEPTH)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= SIGN_FLIP;
         max_ff   <= SIGN_FLIP;
         count_ff <= '0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         count_ff <= count_in;
      end
   end

   // sample store: write at the fill position, read on render accept
   always_ff @(posedge clock) begin
      if (store_write) begin
         sample_store[req_first_of_frame ? '0 : count_ff[STORE_IDX_BITS-1:0]] <= key;
      end
      if (render_accept) begin
         rd_ff <= sample_store[req_pixel_index[STORE_IDX_BITS-1:0]];
         ok_ff <= (COUNT_BITS'(req_pixel_index) < count_ff) && (max_ff > min_ff);
      end
   end

   // divider operands; min and max hold while a render is in flight
   assign num = (rd_ff > min_ff) ? (rd_ff - min_ff) : '0;
   assign den = max_ff - min_ff;

   mmjc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (num),
      .divisor   (den),
      .div_done  (div_done),
      .quotient  (div_q)
   );

   // jet pieces on t = div_q, u = 4t
   always_comb begin
      u    = signed'(CH_BITS'({div_q, 2'b00}));
      r_ch = '0;
      g_ch = '0;
      b_ch = '0;
      if (div_q < T_BREAK1) begin
         b_ch = u + CH_HALF;
      end else if (div_q < T_BREAK2) begin
         g_ch = u - CH_HALF;
         b_ch = CH_ONE;
      end else if (div_q < T_BREAK3) begin
         r_ch = u - CH_3HALF;
         g_ch = CH_ONE;
         b_ch = CH_5HALF - u;
      end else if (div_q < T_BREAK4) begin
         r_ch = CH_ONE;
         g_ch = CH_7HALF - u;
      end else begin
         r_ch = CH_9HALF - u;
      end
   end

   // sequencer: read, start divide, wait for the last quotient bit, map
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      rsp_valid_in = 1'b0;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      index_ok_in  = index_ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (render_accept) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            // drop the color for an unloaded index or a flat frame
            rsp_valid_in = 1'b1;
            red_in       = ok_ff ? chan_to_byte(r_ch) : 8'd0;
            green_in     = ok_ff ? chan_to_byte(g_ch) : 8'd0;
            blue_in      = ok_ff ? chan_to_byte(b_ch) : 8'd0;
            index_ok_in  = ok_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      index_ok_ff <= index_ok_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_red      = red_ff;
   assign rsp_green    = green_ff;
   assign rsp_blue     = blue_ff;
   assign rsp_index_ok = index_ok_ff;

endmodule

`default_nettype wire

FILE: rtl/mmjc_checker.sv
// Port-level checks for the jet colormap renderer, bound to the top level.
`default_nettype none

module mmjc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               req_op,
   input wire logic                               rsp_valid,
   input wire logic [7:0]                         rsp_red,
   input wire logic [7:0]                         rsp_green,
   input wire logic [7:0]                         rsp_blue,
   input wire logic                               rsp_index_ok
);
   import mmjc_pkg::*;

   // a render request occupies the block
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_RENDER) |=> busy)
      else $error("render request did not raise busy");

   // a load request finishes at once
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_LOAD) |=> (!busy && !rsp_valid))
      else $error("load request held the block or gave a response");

   // a response is shown only once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // one response per render: never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // a rejected index or flat frame comes out black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_ok) |-> (rsp_red == 8'd0 && rsp_green == 8'd0 &&
                                         rsp_blue == 8'd0))
      else $error("response without index_ok is not black");

endmodule

bind minmax_normalized_jet_colormap mmjc_checker u_mmjc_checker (.*);

`default_nettype wire

FILE: test/tb_minmax_normalized_jet_colormap.sv
// Self-checking testbench for the min/max normalized jet colormap renderer.
module tb_minmax_normalized_jet_colormap;
   timeunit 1ns;
   timeprecision 1ps;

   import mmjc_pkg::*;

   // One rendered pixel as the block shows it.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       index_ok;
   } jet_color_type;

   // Tracks the frame the block should hold and the colors still owed by it.
   class jet_scoreboard;
      bit [SAMPLE_BITS-1:0] keys [STORE_DEPTH];  // samples with the sign bit flipped
      bit [SAMPLE_BITS-1:0] lo_key;
      bit [SAMPLE_BITS-1:0] hi_key;
      int unsigned          loaded;
      jet_color_type        expected_colors[$];
      int unsigned          mismatches;

      function new();
         lo_key = SIGN_FLIP;
         hi_key = SIGN_FLIP;
         loaded = 0;
         mismatches = 0;
      endfunction

      function logic [7:0] channel_to_level(int c);
         if (c < 0) c = 0;
         if (c > ONE) c = ONE;
         return 8'((c * 255) >> FRAC_BITS);
      endfunction

      function jet_color_type jet_color_of(int unsigned idx);
         jet_color_type     c;
         longint unsigned   span;
         longint unsigned   offset;
         longint unsigned   quot;
         int                t;
         int                u;
         int                r;
         int                g;
         int                b;
         c = '0;
         r = 0;
         g = 0;
         b = 0;
         if (idx < loaded && hi_key > lo_key) begin
            span = {32'd0, hi_key} - {32'd0, lo_key};
            offset = (keys[idx] > lo_key) ? ({32'd0, keys[idx]} - {32'd0, lo_key}) : 0;
            quot = (offset << FRAC_BITS) / span;
            if (quot > ONE) quot = ONE;
            t = int'(quot);
            u = 4 * t;
            if (t < ONE / 8) begin
               b = u + ONE / 2;
            end else if (t < 3 * ONE / 8) begin
               g = u - ONE / 2;
               b = ONE;
            end else if (t < 5 * ONE / 8) begin
               r = u - 3 * ONE / 2;
               g = ONE;
               b = 5 * ONE / 2 - u;
            end else if (t < 7 * ONE / 8) begin
               r = ONE;
               g = 7 * ONE / 2 - u;
            end else begin
               r = 9 * ONE / 2 - u;
            end
            c.index_ok = 1'b1;
         end
         c.red   = channel_to_level(r);
         c.green = channel_to_level(g);
         c.blue  = channel_to_level(b);
         return c;
      endfunction

      // Apply an accepted request to the frame state; renders owe one color.
      function void note_request(logic op, logic [SAMPLE_BITS-1:0] sample, logic first,
                                 logic [INDEX_BITS-1:0] index);
         bit [SAMPLE_BITS-1:0] key;
         if (op == OP_LOAD) begin
            key = sample ^ SIGN_FLIP;
            if (first) begin
               loaded = 0;
               lo_key = key;
               hi_key = key;
            end else begin
               if (key > hi_key) hi_key = key;
               if (key < lo_key) lo_key = key;
            end
            if (loaded < STORE_DEPTH) begin
               keys[loaded] = key;
               loaded++;
            end
         end else begin
            expected_colors.push_back(jet_color_of(index));
         end
      endfunction

      function void compare_field(string name, int exp_v, int got_v);
         if (exp_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_color(jet_color_type got);
         jet_color_type want;
         if (expected_colors.size() == 0) begin
            $display("%0t: response with no render pending, got %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_colors.pop_front();
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("index_ok", want.index_ok, got.index_ok);
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_op;
   logic signed [SAMPLE_BITS-1:0] req_sample_value;
   logic                          req_first_of_frame;
   logic [INDEX_BITS-1:0]         req_pixel_index;
   logic                          rsp_valid;
   logic [7:0]                    rsp_red;
   logic [7:0]                    rsp_green;
   logic [7:0]                    rsp_blue;
   logic                          rsp_index_ok;

   jet_scoreboard sb;
   int unsigned   sender_idle_pct;
   int unsigned   requests_sent;

   minmax_normalized_jet_colormap dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_sample_value   (req_sample_value),
      .req_first_of_frame (req_first_of_frame),
      .req_pixel_index    (req_pixel_index),
      .rsp_valid          (rsp_valid),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_index_ok       (rsp_index_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Responses last one cycle and cannot be stalled: take each one at the
   // edge that ends it. Values read here are the ones before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_color('{rsp_red, rsp_green, rsp_blue, rsp_index_ok});
      end
   end

   // Hold one request on the ports until an edge sees start high and busy
   // low, then idle the sender at random. Called right after a rising edge.
   // Start is left high when the next request follows at once, so it is
   // never lowered and raised in the same step.
   task automatic send_request(logic op, logic [SAMPLE_BITS-1:0] sample, logic first,
                               logic [INDEX_BITS-1:0] index);
      start              <= 1'b1;
      req_op             <= op;
      req_sample_value   <= sample;
      req_first_of_frame <= first;
      req_pixel_index    <= index;
      do @(posedge clock); while (busy);
      sb.note_request(op, sample, first, index);
      requests_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         start              <= 1'b0;
         req_op             <= 1'($urandom_range(1));
         req_sample_value   <= $urandom;
         req_first_of_frame <= 1'($urandom_range(1));
         req_pixel_index    <= INDEX_BITS'($urandom_range(4095));
         @(posedge clock);
      end
   endtask

   // Unused fields carry random bits so that the block must ignore them.
   task automatic send_load(logic [SAMPLE_BITS-1:0] sample, logic first);
      send_request(OP_LOAD, sample, first, INDEX_BITS'($urandom_range(4095)));
   endtask

   task automatic send_render(logic [INDEX_BITS-1:0] index, logic first);
      send_request(OP_RENDER, $urandom, first, index);
   endtask

   // Mix the extremes, full-range noise and a narrow band near zero.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3, 4: return $urandom;
         default: return 32'($urandom_range(2000)) - 32'd1000;
      endcase
   endfunction

   // Pick an index inside the frame, now and then the one just past it, or anywhere.
   function automatic logic [INDEX_BITS-1:0] pick_index();
      if (sb.loaded == 0 || $urandom_range(9) == 0) return INDEX_BITS'($urandom_range(4095));
      if ($urandom_range(9) == 0) return INDEX_BITS'(sb.loaded);
      return INDEX_BITS'($urandom_range(sb.loaded - 1));
   endfunction

   // Random frames: a frame start, a run of loads with renders mixed in,
   // then a burst of renders. Some frames are flat, some skip the frame
   // start and widen the previous one.
   task automatic render_frames(int unsigned budget);
      int unsigned      first_sent;
      int unsigned      kind;
      int unsigned      nloads;
      int unsigned      nrenders;
      logic [SAMPLE_BITS-1:0] base;
      first_sent = requests_sent;
      while (requests_sent - first_sent < budget) begin
         kind = $urandom_range(9);
         nloads = 1 + $urandom_range(24);
         base = pick_sample();
         send_load(base, kind != 1);
         for (int i = 1; i < nloads; i++) begin
            send_load((kind == 0) ? base : pick_sample(), 1'b0);
            if ($urandom_range(7) == 0) send_render(pick_index(), 1'($urandom_range(1)));
         end
         nrenders = 1 + $urandom_range(8);
         for (int i = 0; i < nrenders; i++) begin
            send_render(pick_index(), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      sb = new();
      sender_idle_pct    = 9;
      requests_sent      = 0;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_op             <= OP_LOAD;
      req_sample_value   <= '0;
      req_first_of_frame <= 1'b0;
      req_pixel_index    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Render before anything is loaded: black, flag clear.
      send_render(12'd0, 1'b0);
      // Load with no frame start widens the reset min and max of zero.
      send_load(32'd100, 1'b0);
      send_render(12'd0, 1'b0);
      // Full-scale frame: intensity at both ends, then an index past the count.
      send_load(32'h8000_0000, 1'b1);
      send_load(32'h7fff_ffff, 1'b0);
      send_render(12'd0, 1'b0);
      send_render(12'd1, 1'b0);
      send_render(12'd2, 1'b0);
      // Flat frame: max equals min.
      send_load(32'd5, 1'b1);
      send_load(32'd5, 1'b0);
      send_render(12'd1, 1'b0);
      // Span of one so the intensity equals the sample; land on the piece
      // breaks and just below the first. The first flag on a render is ignored.
      send_load(32'd0, 1'b1);
      send_load(32'd4096, 1'b0);
      send_load(32'd512, 1'b0);
      send_load(32'd1536, 1'b0);
      send_load(32'd2560, 1'b0);
      send_load(32'd3584, 1'b0);
      send_load(32'd511, 1'b0);
      send_render(12'd2, 1'b0);
      send_render(12'd3, 1'b1);
      send_render(12'd4, 1'b0);
      send_render(12'd5, 1'b0);
      send_render(12'd6, 1'b0);

      render_frames(375);
      sender_idle_pct = 87;
      render_frames(375);
      sender_idle_pct = 0;
      render_frames(375);

      // Drain: wait for every owed color, then a render's latency more.
      start <= 1'b0;
      while (sb.expected_colors.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_minmax_normalized_jet_colormap passed");
      end else begin
         $display("tb_minmax_normalized_jet_colormap failed");
      end
      $finish;
   end

   // Backstop against a hung handshake or a lost response.
   initial begin
      #5_000_000;
      $display("tb_minmax_normalized_jet_colormap failed");
      $finish;
   end

endmodule
